// ===== design/sbmq_pkg.sv =====
// Package for the shared-buffer multi-queue: field widths, request and status codes.
// No dependencies; the interfaces, the multi-queue and the checker import it.
`default_nettype none

package sbmq_pkg;

	// Fixed field widths of the request and response items.
	localparam int DATA_W   = 32;
	localparam int QNUM_W   = 2;
	localparam int STATUS_W = 2;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic signed [DATA_W-1:0] data_t;

	// Request kinds.
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// Response status codes.
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	// Data word returned by a dequeue from an empty queue, and by every enqueue.
	localparam data_t UNDERFLOW_DATA = '1;
	localparam data_t ENQ_DATA       = '0;

endpackage

`default_nettype wire

// ===== design/sbmq_if.sv =====
// Valid/ready channel interfaces for requests and responses of the multi-queue.
// Depends on sbmq_pkg for field widths.
`default_nettype none

interface sbmq_req_if;
	import sbmq_pkg::*;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [QNUM_W-1:0] queue_num;
	data_t       write_data;

	modport source(output valid, req_type, queue_num, write_data, input ready);
	modport sink(input valid, req_type, queue_num, write_data, output ready);
endinterface

interface sbmq_rsp_if;
	import sbmq_pkg::*;
	logic    valid;
	logic    ready;
	data_t   read_data;
	status_t status;

	modport source(output valid, read_data, status, input ready);
	modport sink(input valid, read_data, status, output ready);
endinterface

`default_nettype wire

// ===== design/sbmq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered,
// read-first output that holds while no read is enabled. No dependencies.
`default_nettype none

module sbmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// A read and a write to the same address in one cycle return the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

// ===== design/shared_buffer_multi_queue.sv =====
// Shared-buffer multi-queue: QUEUES linked FIFO queues in one slot store.
// Depends on sbmq_pkg, sbmq_req_if / sbmq_rsp_if and sbmq_ram.
//
// Usage: each request on req enqueues write_data to queue_num (req_type 0) or
// dequeues from queue_num (req_type 1). Every request yields exactly one
// response on rsp, in request order: the dequeued word with status OK, status
// FULL with data 0 when no slot is free, or status EMPTY with data -1 when the
// queue holds nothing. A queue number at or above QUEUES is treated as a queue
// that does not exist.
// Throughput is one request per clock while the receiver keeps up. The slot
// data RAM is read at the accepting edge into the read stage, and the response
// register loads from the read stage once it is free; it drives rsp.valid.
// Pointer chasing through the link RAM keeps pace because the link read issued
// for one request is consumed by the next one.
// Reset empties every queue and makes every slot free at once; the RAMs are
// not cleared, since never-used slots are handed out by a fill counter.
// When the receiver stalls, one response waits in the output register and one
// more in the read stage; then req.ready drops until the output moves again.
`default_nettype none

module shared_buffer_multi_queue #(
	parameter int SLOTS  = 16,
	parameter int QUEUES = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	sbmq_req_if.sink   req,
	sbmq_rsp_if.source rsp
);
	import sbmq_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	// Queue and free-list pointers.
	logic [LW-1:0] head_q [QUEUES];
	logic [LW-1:0] tail_q [QUEUES];
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] fresh_q;
	logic          pend_free_q;
	logic          pend_head_q;
	logic [QW-1:0] pend_queue_q;

	// Read stage and response register.
	logic    valid_s1;
	logic    deq_s1;
	status_t status_s1;
	logic    out_valid_q;
	data_t   read_data_q;
	status_t status_q;

	logic          acc;
	logic          in_ready;
	logic          move;
	logic          is_deq;
	logic [QW-1:0] qi;
	logic          q_ok;
	logic [LW-1:0] cur_free;
	logic [LW-1:0] cur_head;
	logic [LW-1:0] cur_tail;
	logic          take_chain;
	logic [LW-1:0] alloc;
	logic          enq_ok;
	logic          deq_ok;
	status_t       status_d;

	logic          link_we;
	logic [SW-1:0] link_waddr;
	logic [LW-1:0] link_wdata;
	logic          link_re;
	logic [SW-1:0] link_raddr;
	logic [LW-1:0] link_rd;
	logic          data_we;
	logic          data_re;
	logic [DATA_W-1:0] data_rd;

	// Handshakes: the read stage frees up when it can move into the output.
	assign move     = valid_s1 && (!out_valid_q || rsp.ready);
	assign in_ready = !valid_s1 || move;
	assign acc      = req.valid && in_ready;
	assign req.ready = in_ready;

	// Request decode.
	assign is_deq = (req.req_type == REQ_DEQ);
	assign qi     = QW'(req.queue_num);
	assign q_ok   = (32'(req.queue_num) < 32'(QUEUES));

	// Current pointers; a link read issued last cycle supersedes the stale register.
	assign cur_free = pend_free_q ? link_rd : free_head_q;
	assign cur_head = (pend_head_q && (pend_queue_q == qi)) ? link_rd : head_q[qi];
	assign cur_tail = tail_q[qi];

	// Allocation: recycled slots first, then slots that were never used.
	assign take_chain = (cur_free != NIL);
	assign alloc      = take_chain ? cur_free : fresh_q;
	assign enq_ok     = q_ok && (take_chain || (fresh_q != NIL));
	assign deq_ok     = q_ok && (cur_head != NIL);

	always_comb begin
		if (is_deq) begin
			status_d = deq_ok ? ST_OK : ST_EMPTY;
		end else begin
			status_d = enq_ok ? ST_OK : ST_FULL;
		end
	end

	// Link RAM: enqueue follows the free chain and appends to the tail;
	// dequeue follows the queue chain and pushes its slot on the free chain.
	assign link_re = acc && (is_deq ? (deq_ok && (cur_head != cur_tail))
	                                : (enq_ok && take_chain));
	assign link_raddr = is_deq ? cur_head[SW-1:0] : cur_free[SW-1:0];
	assign link_we = acc && (is_deq ? deq_ok : (enq_ok && (cur_head != NIL)));
	assign link_waddr = is_deq ? cur_head[SW-1:0] : cur_tail[SW-1:0];
	assign link_wdata = is_deq ? cur_free : alloc;

	sbmq_ram #(
		.WIDTH(LW),
		.DEPTH(SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.re   (link_re),
		.raddr(link_raddr),
		.rdata(link_rd)
	);

	// Slot data RAM.
	assign data_we = acc && !is_deq && enq_ok;
	assign data_re = acc && is_deq && deq_ok;

	sbmq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(SLOTS)
	) u_data_ram (
		.clk  (clk),
		.we   (data_we),
		.waddr(alloc[SW-1:0]),
		.wdata(req.write_data),
		.re   (data_re),
		.raddr(cur_head[SW-1:0]),
		.rdata(data_rd)
	);

	// Pointer state: commit pending link reads, then apply this request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
			free_head_q <= NIL;
			fresh_q     <= '0;
			pend_free_q <= 1'b0;
			pend_head_q <= 1'b0;
		end else begin
			pend_free_q <= 1'b0;
			pend_head_q <= 1'b0;
			if (pend_free_q) begin
				free_head_q <= link_rd;
			end
			if (pend_head_q) begin
				head_q[pend_queue_q] <= link_rd;
			end
			if (acc) begin
				if (!is_deq) begin
					if (enq_ok) begin
						if (take_chain) begin
							pend_free_q <= 1'b1;
						end else begin
							fresh_q <= fresh_q + LW'(1);
						end
						if (cur_head == NIL) begin
							head_q[qi] <= alloc;
						end
						tail_q[qi] <= alloc;
					end
				end else if (deq_ok) begin
					free_head_q <= cur_head;
					if (cur_head == cur_tail) begin
						head_q[qi] <= NIL;
					end else begin
						pend_head_q <= 1'b1;
					end
				end
			end
		end
	end

	// Queue whose next head is in flight from the link RAM.
	always_ff @(posedge clk) begin
		if (acc && is_deq && deq_ok) begin
			pend_queue_q <= qi;
		end
	end

	// Read stage and response register valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= req.valid;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload: the data RAM output is valid while the read stage holds.
	always_ff @(posedge clk) begin
		if (acc) begin
			deq_s1    <= is_deq;
			status_s1 <= status_d;
		end
		if (move) begin
			status_q <= status_s1;
			if (!deq_s1) begin
				read_data_q <= ENQ_DATA;
			end else if (status_s1 == ST_OK) begin
				read_data_q <= data_rd;
			end else begin
				read_data_q <= UNDERFLOW_DATA;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.status    = status_q;
endmodule

`default_nettype wire

// ===== design/sbmq_checker.sv =====
// Port-level checker for the shared-buffer multi-queue, bound to the top level.
// Depends on sbmq_pkg for status codes and on shared_buffer_multi_queue.
`default_nettype none

module sbmq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire sbmq_pkg::data_t   read_data,
	input wire sbmq_pkg::status_t status
);
	import sbmq_pkg::*;

	// A stalled response keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
		else $error("response changed while stalled");

	// Every accepted request shows a response after the read stage and the response register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no response two cycles after a request");

	// A dropped enqueue reports a zero data word.
	a_full_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (read_data == ENQ_DATA))
		else $error("full status with nonzero data");

	// An underflow reports the all-ones data word.
	a_empty_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (read_data == UNDERFLOW_DATA))
		else $error("underflow status with wrong data");
endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (req.valid),
	.in_ready (req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.read_data(rsp.read_data),
	.status   (rsp.status)
);

`default_nettype wire
